FILE: rtl/thc_pkg.sv
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Shared widths, fixed-point constants, stage records and the arctangent table.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int MAG_W   = 16;  // raw magnetometer axis
    localparam int ANG_W   = 15;  // tilt angle, 1/64 degree
    localparam int HDG_W   = 15;  // heading, 1/64 degree
    localparam int DECL_W  = 12;  // declination register
    localparam int ROT_W   = 33;  // rotation datapath, Q30
    localparam int ROT_ZW  = 26;  // rotation residual angle, 2^-16 degree
    localparam int TRIG_W  = 18;  // sine and cosine, Q16
    localparam int ANG_IW  = 27;  // wide angle for wrapping and vectoring
    localparam int VEC_W   = 54;  // vectoring datapath
    localparam int ATAN_W  = 24;

    localparam logic signed [ROT_W-1:0]  INV_GAIN   = 33'sd652032874;
    localparam logic signed [ANG_IW-1:0] DEG90      = 27'sd5898240;
    localparam logic signed [ANG_IW-1:0] DEG180     = 27'sd11796480;
    localparam logic signed [ANG_IW-1:0] DEG360     = 27'sd23592960;
    localparam logic signed [DECL_W-1:0] DECL_RESET = 12'sd621;

    typedef struct packed {
        logic signed [MAG_W-1:0] x;
        logic signed [MAG_W-1:0] y;
        logic signed [MAG_W-1:0] z;
    } t_mag;

    typedef struct packed {
        logic signed [ROT_W-1:0]  x;
        logic signed [ROT_W-1:0]  y;
        logic signed [ROT_ZW-1:0] z;
        logic                     flip;
    } t_rot;

    typedef struct packed {
        logic signed [VEC_W-1:0]  x;
        logic signed [VEC_W-1:0]  y;
        logic signed [ANG_IW-1:0] z;
        logic                     zero;
    } t_vec;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
    function automatic logic signed [ATAN_W-1:0] atan_entry(input int idx);
        logic signed [ATAN_W-1:0] v;
        unique case (idx)
            0:  v = 24'sd2949120;
            1:  v = 24'sd1740967;
            2:  v = 24'sd919879;
            3:  v = 24'sd466945;
            4:  v = 24'sd234379;
            5:  v = 24'sd117304;
            6:  v = 24'sd58666;
            7:  v = 24'sd29335;
            8:  v = 24'sd14668;
            9:  v = 24'sd7334;
            10: v = 24'sd3667;
            11: v = 24'sd1833;
            12: v = 24'sd917;
            13: v = 24'sd458;
            14: v = 24'sd229;
            15: v = 24'sd115;
            16: v = 24'sd57;
            17: v = 24'sd29;
            18: v = 24'sd14;
            19: v = 24'sd7;
            20: v = 24'sd4;
            21: v = 24'sd2;
            22: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading
// Magnetometer sample plus two tilt angles in, heading in 1/64 degree out.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock cycle while the pipeline is not
// held and returns one heading per sample, in order. The path runs through
// chains of CORDIC cells: a rotation chain for each tilt angle that
// produces its sine and cosine, and a vectoring chain that turns the
// horizontal field components into an angle. In between sit a rounding
// stage for the sine and cosine, three multiply stages and a vectoring
// set-up stage, and the input and output registers close the path at both
// ends. The whole pipeline advances together; it holds only when a
// finished heading sits in the output register and the downstream side
// does not take it. The heading equals atan2(h1, h2) minus the declination
// register and is not wrapped.
// ----------------------------------------------------------------------------
module tilt_compensated_heading import thc_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Sample input. tdata from bit 0: field_x[15:0], field_y[15:0],
    // field_z[15:0], tilt_a[14:0], tilt_b[14:0], two zero bits.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [79:0]       s_axis_tdata,
    // Heading output. tdata from bit 0: heading[14:0], one zero bit.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,
    // Declination register write.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DECL_W-1:0] i_cfg_data
);

    localparam int N = CORDIC_STAGES;

    // Pipeline enable: everything moves unless the output is full and stalled.
    logic en;
    logic accept;

    logic signed [DECL_W-1:0] r_decl;

    // Rotation chain, magnetometer side line and valid bits.
    t_rot r_rot_a [0:N];
    t_rot r_rot_b [0:N];
    t_mag r_mag   [0:N];
    logic r_v     [0:N];

    // Trig stage.
    logic signed [TRIG_W-1:0] r_sa, r_ca, r_sb, r_cb;
    t_mag r_mag_t;
    logic r_vt;

    // Product stages.
    logic signed [33:0] r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [TRIG_W-1:0] r_sa1, r_sa2;
    logic r_v1, r_v2, r_v3;
    logic signed [VEC_W-1:0] r_h1_2, r_h1_3, r_h2_3;
    logic signed [34:0] r_s2;
    logic signed [33:0] r_p5_2;

    // Vectoring chain.
    t_vec r_vec [0:N];
    logic r_vv  [0:N];

    logic signed [HDG_W-1:0] r_hdg;
    logic r_ov;

    logic signed [ANG_W-1:0] tilt_a, tilt_b;
    t_mag mag_in;
    t_vec n_vec0;
    logic signed [ANG_IW-1:0] ang;

    function automatic t_rot rot_init(input logic signed [ANG_W-1:0] raw);
        logic signed [ANG_IW-1:0] z;
        t_rot r;
        z = {{2{raw[ANG_W-1]}}, raw, 10'b0};
        if (z >= DEG180) begin
            z = z - DEG360;
        end else if (z < -DEG180) begin
            z = z + DEG360;
        end
        r.flip = 1'b0;
        if (z > DEG90) begin
            z = z - DEG180;
            r.flip = 1'b1;
        end else if (z < -DEG90) begin
            z = z + DEG180;
            r.flip = 1'b1;
        end
        r.x = INV_GAIN;
        r.y = '0;
        r.z = ROT_ZW'(z);
        return r;
    endfunction

    // Round a Q30 value to Q16 and apply the half-turn fold.
    function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [ROT_W-1:0] v,
                                                       input logic flip);
        logic signed [ROT_W-1:0] t;
        logic signed [TRIG_W-1:0] q;
        t = (v + ROT_W'(8192)) >>> 14;
        q = TRIG_W'(t);
        return flip ? -q : q;
    endfunction

    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign o_cfg_ready   = 1'b1;

    assign mag_in.x = s_axis_tdata[15:0];
    assign mag_in.y = s_axis_tdata[31:16];
    assign mag_in.z = s_axis_tdata[47:32];
    assign tilt_a   = s_axis_tdata[62:48];
    assign tilt_b   = s_axis_tdata[77:63];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
        end else if (i_cfg_valid) begin
            r_decl <= i_cfg_data;
        end
    end

    // Input stage: wrap and fold both tilt angles into the CORDIC range.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot_a[0] <= rot_init(tilt_a);
            r_rot_b[0] <= rot_init(tilt_b);
            r_mag[0]   <= mag_in;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        thc_rot_cell #(.STAGE(k)) u_cell_a (
            .i_clk(i_clk), .i_en(en), .i_d(r_rot_a[k]), .o_q(r_rot_a[k+1])
        );
        thc_rot_cell #(.STAGE(k)) u_cell_b (
            .i_clk(i_clk), .i_en(en), .i_d(r_rot_b[k]), .o_q(r_rot_b[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mag[k+1] <= r_mag[k];
            end
        end
    end

    // Trig, products and the two horizontal components.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ca    <= to_q16(r_rot_a[N].x, r_rot_a[N].flip);
            r_sa    <= to_q16(r_rot_a[N].y, r_rot_a[N].flip);
            r_cb    <= to_q16(r_rot_b[N].x, r_rot_b[N].flip);
            r_sb    <= to_q16(r_rot_b[N].y, r_rot_b[N].flip);
            r_mag_t <= r_mag[N];

            r_p1  <= 34'(r_mag_t.z) * 34'(r_sb);
            r_p2  <= 34'(r_mag_t.y) * 34'(r_cb);
            r_p3  <= 34'(r_mag_t.y) * 34'(r_sb);
            r_p4  <= 34'(r_mag_t.z) * 34'(r_cb);
            r_p5  <= 34'(r_mag_t.x) * 34'(r_ca);
            r_sa1 <= r_sa;

            r_h1_2 <= VEC_W'(35'(r_p1) - 35'(r_p2)) <<< 16;
            r_s2   <= 35'(r_p3) + 35'(r_p4);
            r_p5_2 <= r_p5;
            r_sa2  <= r_sa1;

            r_h1_3 <= r_h1_2;
            r_h2_3 <= (VEC_W'(r_p5_2) <<< 16) + VEC_W'(r_sa2) * VEC_W'(r_s2);
        end
    end

    // Vectoring set-up: zero vector flag and the half-turn for negative h2.
    always_comb begin
        n_vec0.zero = (r_h1_3 == '0) && (r_h2_3 == '0);
        if (r_h2_3[VEC_W-1]) begin
            n_vec0.x = -r_h2_3;
            n_vec0.y = -r_h1_3;
            n_vec0.z = r_h1_3[VEC_W-1] ? -DEG180 : DEG180;
        end else begin
            n_vec0.x = r_h2_3;
            n_vec0.y = r_h1_3;
            n_vec0.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec[0] <= n_vec0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_vec
        thc_vec_cell #(.STAGE(k)) u_cell (
            .i_clk(i_clk), .i_en(en), .i_d(r_vec[k]), .o_q(r_vec[k+1])
        );
    end

    // Convert to 1/64 degree with rounding and remove the declination.
    assign ang = r_vec[N].zero ? '0 : r_vec[N].z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hdg <= HDG_W'(((ang + ANG_IW'(512)) >>> 10) - ANG_IW'(r_decl));
        end
    end

    // Valid bits follow the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_v[k]  <= 1'b0;
                r_vv[k] <= 1'b0;
            end
            r_vt <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= accept;
            for (int k = 0; k < N; k++) begin
                r_v[k+1]  <= r_v[k];
                r_vv[k+1] <= r_vv[k];
            end
            r_vt     <= r_v[N];
            r_v1     <= r_vt;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_vv[0]  <= r_v3;
            r_ov     <= r_vv[N];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_hdg};

    // A stalled pipeline must not lose or create items in flight.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v3) && $stable(r_vt) && $stable(r_ov))
        else $error("pipeline valid bits moved during a stall");

    // An accepted sample shows up at the entry of the rotation chain.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v[0])
        else $error("accepted sample not captured");

    // Reset restores the default declination.
    a_decl_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> r_decl == DECL_RESET)
        else $error("declination not at reset value");

endmodule

FILE: rtl/thc_rot_cell.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One micro-rotation toward zero residual angle; yields cosine and sine.
// ----------------------------------------------------------------------------
module thc_rot_cell import thc_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_rot i_d,
    output t_rot o_q
);

    localparam logic signed [ROT_ZW-1:0] ATAN = ROT_ZW'(atan_entry(STAGE));

    t_rot r_q;
    t_rot n_q;
    logic signed [ROT_W-1:0] xsh;
    logic signed [ROT_W-1:0] ysh;

    always_comb begin
        xsh      = i_d.x >>> STAGE;
        ysh      = i_d.y >>> STAGE;
        n_q.flip = i_d.flip;
        if (!i_d.z[ROT_ZW-1]) begin
            n_q.x = i_d.x - ysh;
            n_q.y = i_d.y + xsh;
            n_q.z = i_d.z - ATAN;
        end else begin
            n_q.x = i_d.x + ysh;
            n_q.y = i_d.y - xsh;
            n_q.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/thc_vec_cell.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation driving y toward zero while accumulating the angle.
// ----------------------------------------------------------------------------
module thc_vec_cell import thc_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_d,
    output t_vec o_q
);

    localparam logic signed [ANG_IW-1:0] ATAN = ANG_IW'(atan_entry(STAGE));

    t_vec r_q;
    t_vec n_q;
    logic signed [VEC_W-1:0] xsh;
    logic signed [VEC_W-1:0] ysh;

    always_comb begin
        xsh      = i_d.x >>> STAGE;
        ysh      = i_d.y >>> STAGE;
        n_q.zero = i_d.zero;
        if (!i_d.y[VEC_W-1]) begin
            n_q.x = i_d.x + ysh;
            n_q.y = i_d.y - xsh;
            n_q.z = i_d.z + ATAN;
        end else begin
            n_q.x = i_d.x - ysh;
            n_q.y = i_d.y + xsh;
            n_q.z = i_d.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
